// File: hdl/spbd_pkg.sv
// Shared types and constants for the scrolling pitch bar display.
// No dependencies; imported by every module of the block.
`default_nettype none

package spbd_pkg;

  localparam int MAP_ROWS   = 8;
  localparam int ROW_W      = 3;
  localparam int FREQ_W     = 16;
  localparam int NUM_THRESH = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CHAN_W     = 8;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes, in register order.
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_H2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_H3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_H4 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_H5 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_H6 = 3'd4;

  localparam logic [FREQ_W-1:0] THRESH_RESET [NUM_THRESH] =
    '{16'd300, 16'd400, 16'd500, 16'd600, 16'd700};

  localparam logic [CHAN_W-1:0] RED_BASE = 8'd255;
  localparam logic [CHAN_W-1:0] LUM_MIN  = 8'd170;
  localparam int                LUM_SPAN = 80;

  // Green base of the yellow-orange-red gradient, indexed by row (0 is top).
  localparam logic [CHAN_W-1:0] GREEN_BASE [MAP_ROWS] =
    '{8'd1, 8'd41, 8'd80, 8'd121, 8'd157, 8'd190, 8'd222, 8'd255};

  typedef logic [MAP_ROWS-1:0] column_t;

  // Per-cycle control of one column cell.
  typedef struct packed {
    logic shift;  // take the left neighbor (scroll right)
    logic flush;  // with shift: take zero instead
    logic rot;    // take the right neighbor (scan rotation)
  } cell_ctl_t;

  // One pixel handed to the shading stage.
  typedef struct packed {
    logic              lit;
    logic [ROW_W-1:0]  row;
    logic [2:0]        col;
    logic [CHAN_W-1:0] lum;
    logic              last;
  } pix_req_t;

endpackage

`default_nettype wire

// File: hdl/spbd_cell.sv
// One column of the pixel map: holds eight on/off bits, top row in bit 0.
// Depends on spbd_pkg.
`default_nettype none

module spbd_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  spbd_pkg::cell_ctl_t  ctl,
  input  spbd_pkg::column_t    left_in,
  input  spbd_pkg::column_t    right_in,
  output spbd_pkg::column_t    col_bits
);
  import spbd_pkg::*;

  column_t bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (ctl.shift) begin
      bits <= ctl.flush ? '0 : left_in;
    end else if (ctl.rot) begin
      bits <= right_in;
    end
  end

  assign col_bits = bits;

endmodule

`default_nettype wire

// File: hdl/spbd_shade.sv
// Pixel shading and output register: gradient color times column brightness.
// Depends on spbd_pkg.
`default_nettype none

module spbd_shade (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          load,
  input  spbd_pkg::pix_req_t           req,
  output logic                         free,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [spbd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);
  import spbd_pkg::*;

  logic [2*CHAN_W-1:0] red_prod;
  logic [2*CHAN_W-1:0] green_prod;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;

  assign red_prod   = (2*CHAN_W)'(RED_BASE) * (2*CHAN_W)'(req.lum);
  assign green_prod = (2*CHAN_W)'(GREEN_BASE[req.row]) * (2*CHAN_W)'(req.lum);

  always_comb begin
    red   = req.lit ? red_prod[2*CHAN_W-1:CHAN_W] : '0;
    green = req.lit ? green_prod[2*CHAN_W-1:CHAN_W] : '0;
    blue  = '0;
  end

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, blue, green, red, req.row, req.col};
      m_tlast <= req.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/scrolling_pitch_bar_display.sv
// Scrolling pitch bar display, top level: threshold registers, bar height,
// the chain of column cells, scan control. Depends on spbd_pkg, spbd_cell,
// spbd_shade.
//
//   channel  dir  signals                          word
//   s        in   s_tvalid s_tready s_tdata s_tuser one note
//   m        out  m_tvalid m_tready m_tdata m_tlast one pixel
//   cfg      in   cfg_we cfg_index cfg_data         one threshold write
//
// A note is taken while the scan is idle: the map is cleared if asked, every
// column cell takes its left neighbor and cell 0 takes the new bar. The scan
// then emits 8 * MAP_COLS pixels, one per cycle while m_tready allows, by
// rotating the cell chain left so cell 0 always holds the current column.
// A low m_tready stalls the scan; no new note is taken until it ends.
// Reset (rst, synchronous) empties the map and loads the default thresholds.
`default_nettype none

module scrolling_pitch_bar_display #(
  parameter int MAP_COLS = 8
) (
  input  wire                                clk,
  input  wire                                rst,
  // note word
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [spbd_pkg::FREQ_W-1:0]        s_tdata,   // [15:0] note_freq
  input  wire                                s_tuser,   // [0] clear_map
  // pixel word
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // [2:0] pix_col, [5:3] pix_row, [13:6] red, [21:14] green, [29:22] blue
  output logic [spbd_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast,   // frame_last
  // configuration
  input  wire                                cfg_we,
  input  wire  [spbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [spbd_pkg::FREQ_W-1:0]        cfg_data
);
  import spbd_pkg::*;

  localparam int COL_W = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int SPAN  = MAP_COLS - 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

  // Threshold registers.
  logic [FREQ_W-1:0] thresh [NUM_THRESH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THRESH; i++) thresh[i] <= THRESH_RESET[i];
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_THRESH; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) thresh[i] <= cfg_data;
      end
    end
  end

  // Bar height: first threshold that holds decides; silence gives zero.
  logic [ROW_W-1:0] height;
  column_t          bar;

  always_comb begin
    if (s_tdata == '0)                       height = 3'd0;
    else if (s_tdata < thresh[REG_THRESH_H2]) height = 3'd2;
    else if (s_tdata < thresh[REG_THRESH_H3]) height = 3'd3;
    else if (s_tdata < thresh[REG_THRESH_H4]) height = 3'd4;
    else if (s_tdata < thresh[REG_THRESH_H5]) height = 3'd5;
    else if (s_tdata < thresh[REG_THRESH_H6]) height = 3'd6;
    else                                      height = 3'd7;
  end

  // Light the bottom rows of the new column.
  always_comb begin
    for (int r = 0; r < MAP_ROWS; r++) begin
      bar[r] = (ROW_W'(MAP_ROWS - 1 - r) < height);
    end
  end

  // Scan control.
  logic             busy;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             accept;
  logic             advance;
  logic             free;
  logic             frame_end;

  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign advance   = busy && free;
  assign frame_end = (row == ROW_LAST) && (col == COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
      col  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      row  <= '0;
      col  <= '0;
    end else if (advance) begin
      if (col == COL_LAST) begin
        col <= '0;
        row <= row + 1'b1;
        if (row == ROW_LAST) busy <= 1'b0;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Chain of column cells: scroll right on a note, rotate left on each pixel.
  column_t   col_data [MAP_COLS];
  cell_ctl_t ctl_head;
  cell_ctl_t ctl_body;

  assign ctl_head = '{shift: accept, flush: 1'b0, rot: advance};
  assign ctl_body = '{shift: accept, flush: s_tuser, rot: advance};

  for (genvar i = 0; i < MAP_COLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      spbd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl_head),
        .left_in  (bar),
        .right_in (col_data[(i + 1) % MAP_COLS]),
        .col_bits (col_data[i])
      );
    end else begin : g_body
      spbd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl_body),
        .left_in  (col_data[i - 1]),
        .right_in (col_data[(i + 1) % MAP_COLS]),
        .col_bits (col_data[i])
      );
    end
  end

  // Column brightness, fixed per column.
  logic [CHAN_W-1:0] lum_tab [MAP_COLS];

  for (genvar i = 0; i < MAP_COLS; i++) begin : g_lum
    assign lum_tab[i] = CHAN_W'(int'(LUM_MIN) + (i * LUM_SPAN) / SPAN);
  end

  pix_req_t req;

  always_comb begin
    req.lit  = col_data[0][row];
    req.row  = row;
    req.col  = 3'(col);
    req.lum  = lum_tab[col];
    req.last = frame_end;
  end

  spbd_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .req      (req),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A taken note starts its scan at the top-left pixel.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && row == '0 && col == '0)
    else $error("scan did not start at the top-left pixel");

  // The last pixel closes the frame and leaves a tagged word behind.
  assert property (@(posedge clk) disable iff (rst)
    advance && frame_end |=> !busy && m_tvalid && m_tlast)
    else $error("frame end not marked");

  // Between notes the scan counters rest at zero, so the chain is aligned.
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> row == '0 && col == '0)
    else $error("scan counters not at rest while idle");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for scrolling_pitch_bar_display: note words in, pixel words out.
// Depends on spbd_pkg and the RTL of the block. Bar heights, scrolling and
// shading are predicted here and every pixel word is checked in order.

module tb;
  import spbd_pkg::*;

  localparam int MAP_COLS    = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_GUARD = 20;    // idle cycles after the last pixel
  localparam int TAIL_CYCLES = 150;   // watch for stray pixels at the end
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_INDEX   = 1 << CFG_IDX_W;

  // Threshold sets used by the random phases.
  typedef enum int {
    TH_SORTED,
    TH_SCRAMBLED,
    TH_EXTREME,
    TH_DEFAULT
  } thresh_style_t;

  // One pixel word as the block should send it.
  typedef struct packed {
    logic [2:0]        col;
    logic [ROW_W-1:0]  row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [FREQ_W-1:0]     s_tdata = '0;      // [15:0] note_freq
  logic                  s_tuser = 1'b0;    // [0] clear_map
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [2:0] pix_col, [5:3] pix_row, [13:6] red, [21:14] green, [29:22] blue
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;           // frame_last
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FREQ_W-1:0]     cfg_data = '0;

  // Predictor state: lit map and the five thresholds.
  logic [MAP_COLS-1:0] lit_map [MAP_ROWS];
  logic [FREQ_W-1:0]   thresh_lim [NUM_THRESH];
  pixel_t              pending_pixels [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int notes_sent     = 0;
  int pixels_checked = 0;
  int thresh_writes  = 0;
  int cycle_count    = 0;

  scrolling_pitch_bar_display #(.MAP_COLS(MAP_COLS)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycle_count,
               pending_pixels.size());
      $display("scrolling_pitch_bar_display regression: fail");
      $finish;
    end
  end

  // Receiver: drop tready at random with the current stall rate.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  // Height of the bar for one note; first threshold that holds wins.
  function automatic int note_height(input logic [FREQ_W-1:0] freq);
    if (freq == '0) return 0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      if (freq < thresh_lim[k]) return k + 2;
    end
    return 7;
  endfunction

  // Gradient from yellow at the bottom to red at the top, brighter to the right.
  function automatic void shade_lit(input int row, input int col,
                                    output logic [CHAN_W-1:0] red,
                                    output logic [CHAN_W-1:0] green);
    int gy, ty, t, base_g, lum;
    gy = 7 - row;
    ty = (gy * 255) / 7;
    if (ty < 128) begin
      t      = (ty * 2) & 8'hFF;
      base_g = 255 - (115 * t + 255) / 256;
    end else begin
      t      = ((ty - 128) * 2) & 8'hFF;
      base_g = 140 - (140 * t + 255) / 256;
    end
    base_g = base_g & 8'hFF;
    lum    = (170 + (col * 80) / (MAP_COLS - 1)) & 8'hFF;
    red    = CHAN_W'((255 * lum) >> 8);
    green  = CHAN_W'((base_g * lum) >> 8);
  endfunction

  // Apply one accepted note to the map and queue the whole frame it causes.
  function automatic void render_note(input logic [FREQ_W-1:0] freq, input logic clr);
    pixel_t px;
    int     height;
    if (clr) begin
      for (int r = 0; r < MAP_ROWS; r++) lit_map[r] = '0;
    end
    // Scroll right, rightmost column falls off, column 0 starts dark.
    for (int r = 0; r < MAP_ROWS; r++) lit_map[r] = {lit_map[r][MAP_COLS-2:0], 1'b0};
    height = note_height(freq);
    for (int y = 0; y < height; y++) lit_map[MAP_ROWS-1-y][0] = 1'b1;
    for (int r = 0; r < MAP_ROWS; r++) begin
      for (int c = 0; c < MAP_COLS; c++) begin
        px     = '0;
        px.col = 3'(c);
        px.row = ROW_W'(r);
        if (lit_map[r][c]) shade_lit(r, c, px.red, px.green);
        px.last = (r == MAP_ROWS - 1) && (c == MAP_COLS - 1);
        pending_pixels.push_back(px);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] pixel %0d: %s got %0d, want %0d", $time, pixels_checked, what, got,
             want);
    mismatches++;
  endtask

  // Check every pixel word against the oldest predicted one.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word, tdata", int'(m_tdata), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[2:0] !== want.col)
          report_mismatch("col", int'(m_tdata[2:0]), int'(want.col));
        if (m_tdata[5:3] !== want.row)
          report_mismatch("row", int'(m_tdata[5:3]), int'(want.row));
        if (m_tdata[13:6] !== want.red)
          report_mismatch("red", int'(m_tdata[13:6]), int'(want.red));
        if (m_tdata[21:14] !== want.green)
          report_mismatch("green", int'(m_tdata[21:14]), int'(want.green));
        if (m_tdata[29:22] !== want.blue)
          report_mismatch("blue", int'(m_tdata[29:22]), int'(want.blue));
        if (m_tdata[31:30] !== 2'b00)
          report_mismatch("pad", int'(m_tdata[31:30]), 0);
        if (m_tlast !== want.last)
          report_mismatch("tlast", int'(m_tlast), int'(want.last));
      end
      pixels_checked++;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Every task is entered and left at a falling edge.

  // Send one note word; idle first at the sender's current rate.
  task automatic send_note(input logic [FREQ_W-1:0] freq, input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= freq;
    s_tuser  <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    render_note(freq, clr);
    notes_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted pixel has come out.
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_GUARD) @(negedge clk);
  endtask

  // Write one threshold register; only call with the block idle.
  task automatic write_thresh(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESH_H2: thresh_lim[0] = val;
      REG_THRESH_H3: thresh_lim[1] = val;
      REG_THRESH_H4: thresh_lim[2] = val;
      REG_THRESH_H5: thresh_lim[3] = val;
      REG_THRESH_H6: thresh_lim[4] = val;
      default: ;  // no register behind this index
    endcase
    thresh_writes++;
    @(negedge clk);
  endtask

  task automatic write_all_thresh(input logic [FREQ_W-1:0] t2, input logic [FREQ_W-1:0] t3,
                                  input logic [FREQ_W-1:0] t4, input logic [FREQ_W-1:0] t5,
                                  input logic [FREQ_W-1:0] t6);
    write_thresh(REG_THRESH_H2, t2);
    write_thresh(REG_THRESH_H3, t3);
    write_thresh(REG_THRESH_H4, t4);
    write_thresh(REG_THRESH_H5, t5);
    write_thresh(REG_THRESH_H6, t6);
  endtask

  // ---------------------------------------------------------------- tests

  // Default thresholds: silence, every band edge, both ends of the range.
  task automatic test_default_heights();
    send_note(16'd0, 1'b1);
    send_note(16'd1, 1'b0);
    send_note(16'd299, 1'b0);
    send_note(16'd300, 1'b0);
    send_note(16'd399, 1'b0);
    send_note(16'd499, 1'b0);
    send_note(16'd599, 1'b0);
    send_note(16'd699, 1'b0);
    send_note(16'd700, 1'b0);
    send_note(16'hFFFF, 1'b0);
    drain_pixels();
  endtask

  // Clear on a full map, with silence and with a full bar.
  task automatic test_map_clear();
    send_note(16'hFFFF, 1'b0);
    send_note(16'd0, 1'b1);
    send_note(16'hFFFF, 1'b1);
    drain_pixels();
  endtask

  // All thresholds at zero: any nonzero note is full height. All at max:
  // only the top value reaches full height.
  task automatic test_threshold_extremes();
    write_all_thresh(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_note(16'd1, 1'b0);
    send_note(16'd0, 1'b0);
    drain_pixels();
    write_all_thresh(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_note(16'hFFFE, 1'b0);
    send_note(16'hFFFF, 1'b0);
    drain_pixels();
  endtask

  // Thresholds out of order: the first comparison that holds decides.
  task automatic test_threshold_order();
    write_all_thresh(16'd1000, 16'd200, 16'd300, 16'hFFFF, 16'd0);
    send_note(16'd500, 1'b0);
    send_note(16'd1500, 1'b0);
    send_note(16'hFFFF, 1'b0);
    drain_pixels();
  endtask

  // Writes past the last register must leave the thresholds alone.
  task automatic test_unused_index();
    for (int i = int'(REG_THRESH_H6) + 1; i < NUM_INDEX; i++) begin
      write_thresh(CFG_IDX_W'(i), (i % 2 == 0) ? 16'h0000 : 16'hFFFF);
    end
    send_note(16'd250, 1'b0);
    drain_pixels();
  endtask

  // Load a threshold set for one random phase.
  task automatic load_phase_thresh(input thresh_style_t style);
    logic [FREQ_W-1:0] v [NUM_THRESH];
    int                acc;
    acc = $urandom_range(0, 3000);
    for (int k = 0; k < NUM_THRESH; k++) begin
      case (style)
        TH_SORTED: begin
          v[k] = FREQ_W'(acc);
          acc += $urandom_range(0, 3000);
        end
        TH_SCRAMBLED: v[k] = FREQ_W'($urandom_range(0, 65535));
        TH_EXTREME:   v[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default:      v[k] = THRESH_RESET[k];
      endcase
    end
    write_all_thresh(v[0], v[1], v[2], v[3], v[4]);
  endtask

  // One random phase: mostly notes near the band edges and full-range
  // values, some silence, an occasional clear.
  task automatic test_random_phase(input thresh_style_t style, input int idle_pct,
                                   input int stall_pct);
    logic [FREQ_W-1:0] freq;
    int                pick;
    load_phase_thresh(style);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 10)      freq = '0;
      else if (pick < 55) freq = thresh_lim[$urandom_range(NUM_THRESH-1)] +
                                 FREQ_W'($urandom_range(2)) - 16'd1;
      else                freq = FREQ_W'($urandom_range(0, 65535));
      send_note(freq, ($urandom_range(99) < 10));
    end
    drain_pixels();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int r = 0; r < MAP_ROWS; r++) lit_map[r] = '0;
    for (int k = 0; k < NUM_THRESH; k++) thresh_lim[k] = THRESH_RESET[k];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_heights();
    test_map_clear();
    test_threshold_extremes();
    test_threshold_order();
    test_unused_index();

    // Idling phases: none, sender 60%, receiver 60%, both 9%.
    test_random_phase(TH_SORTED, 0, 0);
    test_random_phase(TH_SCRAMBLED, 60, 0);
    test_random_phase(TH_EXTREME, 0, 60);
    test_random_phase(TH_DEFAULT, 9, 9);

    // Anything arriving now is a stray word and the monitor flags it.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch("pixels never sent", 0, pending_pixels.size());

    $display("covered %0d notes, %0d pixel words, %0d threshold writes", notes_sent,
             pixels_checked, thresh_writes);
    $display("four idling phases, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("scrolling_pitch_bar_display regression: pass");
    end else begin
      $display("scrolling_pitch_bar_display regression: fail");
    end
    $finish;
  end

endmodule
